// ===== rtl/core/ffra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and constants of the first-fit range allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int MEM_BYTES_DEF  = 2048;
  localparam int MAX_RANGES_DEF = 64;
  localparam int FIELD_W        = 11;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NO_SPACE  = 2'd1,
    STS_FULL      = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE  = 2'd0,
    FSM_EVAL  = 2'd1,
    FSM_APPLY = 2'd2
  } fsm_t;

  typedef enum logic [1:0] {
    CM_HOLD = 2'd0,
    CM_EVAL = 2'd1,
    CM_INS  = 2'd2,
    CM_REM  = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    op_t        op;
  } cell_cmd_t;

  typedef struct packed {
    logic               op;
    logic [FIELD_W-1:0] req_size;
    logic [FIELD_W-1:0] free_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] alloc_offset;
  } res_t;

endpackage

// ===== rtl/core/ffra_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_cell
// One table entry: holds a range, tests it against a request and shifts
// with its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module ffra_cell #(
  parameter int MEM_BYTES = ffra_pkg::MEM_BYTES_DEF,
  parameter int EW        = 11,
  parameter int IW        = 6,
  parameter int IDX       = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ffra_pkg::cell_cmd_t          cmd,
  input  logic [IW-1:0]                pos,
  input  logic                         valid,
  input  logic                         next_valid,
  input  logic [ffra_pkg::FIELD_W-1:0] req_size,
  input  logic [ffra_pkg::FIELD_W-1:0] free_offset,
  input  logic [EW-1:0]                new_start,
  input  logic [EW-1:0]                new_end,
  input  logic [EW-1:0]                prev_start,
  input  logic [EW-1:0]                prev_end,
  input  logic [EW-1:0]                next_start,
  input  logic [EW-1:0]                next_end,
  output logic [EW-1:0]                start_o,
  output logic [EW-1:0]                end_o,
  output logic                         hit_o
);

  localparam int CW = ((EW > ffra_pkg::FIELD_W) ? EW : ffra_pkg::FIELD_W) + 1;

  logic [EW-1:0] start_r, start_nxt;
  logic [EW-1:0] end_r, end_nxt;
  logic          hit_r, hit_nxt;
  logic [CW-1:0] reach;

  assign reach = CW'(end_r) + CW'(req_size);

  always_comb begin
    start_nxt = start_r;
    end_nxt   = end_r;
    hit_nxt   = hit_r;
    case (cmd.mode)
      ffra_pkg::CM_EVAL: begin
        if (cmd.op == ffra_pkg::OP_ALLOC) begin
          hit_nxt = valid && (next_valid ? (CW'(next_start) > reach)
                                         : (reach < CW'(MEM_BYTES)));
        end else begin
          hit_nxt = valid && (CW'(start_r) == CW'(free_offset));
        end
      end
      ffra_pkg::CM_INS: begin
        if (IW'(IDX) == pos) begin
          start_nxt = new_start;
          end_nxt   = new_end;
        end else if (IW'(IDX) > pos) begin
          start_nxt = prev_start;
          end_nxt   = prev_end;
        end
      end
      ffra_pkg::CM_REM: begin
        if (IW'(IDX) >= pos) begin
          start_nxt = next_start;
          end_nxt   = next_end;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= '0;
      hit_r   <= 1'b0;
    end else begin
      start_r <= start_nxt;
      end_r   <= end_nxt;
      hit_r   <= hit_nxt;
    end
  end

  assign start_o = start_r;
  assign end_o   = end_r;
  assign hit_o   = hit_r;

endmodule

// ===== rtl/core/first_fit_range_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_range_allocator
// First-fit allocator of byte ranges over a fixed heap, table kept sorted.
// ----------------------------------------------------------------------------
// A request is taken on in_req when start is high and busy is low. An
// allocate request (op 0) places req_size bytes in the first gap after an
// existing range, or after the last range; an empty table starts at 1.
// A free request (op 1) removes the range that starts at free_offset.
// The table is a row of cells, one range per cell, that shift toward or
// away from the tail at once on insert or remove.
// Each request passes through accept, a parallel test in every cell,
// the selection and shift, and the result, which is shown on out_res for
// one cycle with out_valid high. The next request may start in that cycle.
// The receiver cannot stall; results are never held back.
// Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module first_fit_range_allocator #(
  parameter int MEM_BYTES  = ffra_pkg::MEM_BYTES_DEF,
  parameter int MAX_RANGES = ffra_pkg::MAX_RANGES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  ffra_pkg::req_t in_req,
  output logic           out_valid,
  output ffra_pkg::res_t out_res
);

  localparam int EW  = $clog2(MEM_BYTES);
  localparam int IW  = $clog2(MAX_RANGES);
  localparam int NW  = $clog2(MAX_RANGES + 1);
  localparam int FW  = ffra_pkg::FIELD_W;
  localparam int CW  = ((EW > FW) ? EW : FW) + 1;

  ffra_pkg::fsm_t      state_r, state_nxt;
  ffra_pkg::req_t      req_r, req_nxt;
  logic [NW-1:0]       count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  ffra_pkg::res_t      res_r, res_nxt;
  ffra_pkg::cell_cmd_t cmd;
  logic [IW-1:0]       pos;
  logic [EW-1:0]       new_start, new_end;

  logic [EW-1:0]         st [MAX_RANGES];
  logic [EW-1:0]         en [MAX_RANGES];
  logic [MAX_RANGES-1:0] hit;
  logic [MAX_RANGES-1:0] valid;

  logic          any_hit;
  logic [IW-1:0] hit_idx;
  logic [CW-1:0] tail_sum;

  always_comb begin
    for (int i = 0; i < MAX_RANGES; i++) begin
      valid[i] = (NW'(i) < count_r);
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_RANGES; g++) begin : g_cell
      logic [EW-1:0] ps, pe, ns, ne;
      logic          nv;
      if (g == 0) begin : g_first
        assign ps = '0;
        assign pe = '0;
      end else begin : g_mid
        assign ps = st[g-1];
        assign pe = en[g-1];
      end
      if (g == MAX_RANGES - 1) begin : g_last
        assign ns = '0;
        assign ne = '0;
        assign nv = 1'b0;
      end else begin : g_inner
        assign ns = st[g+1];
        assign ne = en[g+1];
        assign nv = valid[g+1];
      end
      ffra_cell #(
        .MEM_BYTES(MEM_BYTES),
        .EW       (EW),
        .IW       (IW),
        .IDX      (g)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .pos        (pos),
        .valid      (valid[g]),
        .next_valid (nv),
        .req_size   (req_r.req_size),
        .free_offset(req_r.free_offset),
        .new_start  (new_start),
        .new_end    (new_end),
        .prev_start (ps),
        .prev_end   (pe),
        .next_start (ns),
        .next_end   (ne),
        .start_o    (st[g]),
        .end_o      (en[g]),
        .hit_o      (hit[g])
      );
    end
  endgenerate

  always_comb begin
    hit_idx = '0;
    for (int i = MAX_RANGES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = IW'(i);
      end
    end
  end

  assign any_hit  = |hit;
  assign tail_sum = CW'(en[hit_idx]) + CW'(req_r.req_size);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    cmd.mode      = ffra_pkg::CM_HOLD;
    cmd.op        = ffra_pkg::op_t'(req_r.op);
    pos           = hit_idx;
    new_start     = EW'(tail_sum - CW'(req_r.req_size) + CW'(1));
    new_end       = EW'(tail_sum);
    case (state_r)
      ffra_pkg::FSM_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          state_nxt = ffra_pkg::FSM_EVAL;
        end
      end
      ffra_pkg::FSM_EVAL: begin
        cmd.mode  = ffra_pkg::CM_EVAL;
        state_nxt = ffra_pkg::FSM_APPLY;
      end
      ffra_pkg::FSM_APPLY: begin
        state_nxt            = ffra_pkg::FSM_IDLE;
        out_valid_nxt        = 1'b1;
        res_nxt.alloc_offset = '0;
        if (req_r.op == ffra_pkg::OP_ALLOC) begin
          res_nxt.status = ffra_pkg::STS_NO_SPACE;
          if (count_r == NW'(MAX_RANGES)) begin
            res_nxt.status = ffra_pkg::STS_FULL;
          end else if (req_r.req_size == '0) begin
            res_nxt.status = ffra_pkg::STS_NO_SPACE;
          end else if (count_r == '0) begin
            if (CW'(req_r.req_size) < CW'(MEM_BYTES)) begin
              cmd.mode             = ffra_pkg::CM_INS;
              pos                  = '0;
              new_start            = EW'(1);
              new_end              = EW'(req_r.req_size);
              count_nxt            = count_r + NW'(1);
              res_nxt.status       = ffra_pkg::STS_OK;
              res_nxt.alloc_offset = FW'(1);
            end
          end else if (any_hit) begin
            cmd.mode             = ffra_pkg::CM_INS;
            pos                  = hit_idx + IW'(1);
            count_nxt            = count_r + NW'(1);
            res_nxt.status       = ffra_pkg::STS_OK;
            res_nxt.alloc_offset = FW'(tail_sum - CW'(req_r.req_size) + CW'(1));
          end
        end else begin
          res_nxt.status = ffra_pkg::STS_NOT_FOUND;
          if (any_hit) begin
            cmd.mode       = ffra_pkg::CM_REM;
            count_nxt      = count_r - NW'(1);
            res_nxt.status = ffra_pkg::STS_OK;
          end
        end
      end
      default: begin
        state_nxt = ffra_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffra_pkg::FSM_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
  end

  assign busy      = (state_r != ffra_pkg::FSM_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(MAX_RANGES))
    else $error("range count exceeds table size");

  a_out_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ffra_pkg::FSM_APPLY))
    else $error("result strobe without a finished request");

  a_fail_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status != ffra_pkg::STS_OK) |-> out_res.alloc_offset == '0)
    else $error("failed request reports an offset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

endmodule

// ===== sim/first_fit_range_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_range_allocator_test
// Self-checking bench for the first-fit range allocator.
// ----------------------------------------------------------------------------
// A directed table covers the empty table, size extremes, table full,
// frees of missing offsets and the unused front gap. Random allocate and
// free requests follow, with frees mostly aimed at live ranges. Every result
// is compared with a behavioral copy of the range table kept in this bench.
// ----------------------------------------------------------------------------
module first_fit_range_allocator_test;

  localparam int HEAP   = ffra_pkg::MEM_BYTES_DEF;
  localparam int SLOTS  = ffra_pkg::MAX_RANGES_DEF;
  localparam int NRAND  = 1400;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    ffra_pkg::req_t req;
    logic           chk;
    ffra_pkg::res_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  ffra_pkg::req_t in_req = '0;
  logic out_valid;
  ffra_pkg::res_t out_res;

  int tbl_start [SLOTS];
  int tbl_end [SLOTS];
  int tbl_count;
  ffra_pkg::res_t pending_results [$];
  row_t rows [$];
  int errors = 0;
  int cycles = 0;
  int n_alloc = 0;
  int n_free = 0;
  int n_full = 0;
  int n_nf = 0;
  bit gaps_on = 1'b1;

  first_fit_range_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void tbl_insert(int pos, int s, int e);
    for (int k = tbl_count; k > pos; k--) begin
      tbl_start[k] = tbl_start[k-1];
      tbl_end[k] = tbl_end[k-1];
    end
    tbl_start[pos] = s;
    tbl_end[pos] = e;
    tbl_count++;
  endfunction

  function automatic ffra_pkg::res_t predict_range_op(ffra_pkg::req_t r);
    ffra_pkg::res_t o;
    int sz;
    o = '0;
    sz = int'(r.req_size);
    if (r.op == ffra_pkg::OP_ALLOC) begin
      if (tbl_count >= SLOTS) begin
        o.status = ffra_pkg::STS_FULL;
      end else if (sz == 0) begin
        o.status = ffra_pkg::STS_NO_SPACE;
      end else if (tbl_count == 0) begin
        if (sz >= HEAP) begin
          o.status = ffra_pkg::STS_NO_SPACE;
        end else begin
          tbl_insert(0, 1, sz);
          o.status = ffra_pkg::STS_OK;
          o.alloc_offset = ffra_pkg::FIELD_W'(1);
        end
      end else begin
        o.status = ffra_pkg::STS_NO_SPACE;
        for (int i = 0; i < tbl_count; i++) begin
          bit fits;
          if (i + 1 == tbl_count) begin
            fits = tbl_end[i] + sz < HEAP;
          end else begin
            fits = tbl_start[i+1] > tbl_end[i] && tbl_start[i+1] - tbl_end[i] > sz;
          end
          if (fits) begin
            o.status = ffra_pkg::STS_OK;
            o.alloc_offset = ffra_pkg::FIELD_W'(tbl_end[i] + 1);
            tbl_insert(i + 1, tbl_end[i] + 1, tbl_end[i] + sz);
            break;
          end
        end
      end
    end else begin
      o.status = ffra_pkg::STS_NOT_FOUND;
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_start[i] > int'(r.free_offset)) break;
        if (tbl_start[i] == int'(r.free_offset)) begin
          for (int k = i; k + 1 < tbl_count; k++) begin
            tbl_start[k] = tbl_start[k+1];
            tbl_end[k] = tbl_end[k+1];
          end
          tbl_count--;
          o.status = ffra_pkg::STS_OK;
          break;
        end
      end
    end
    return o;
  endfunction

  function automatic ffra_pkg::req_t mk(logic op, int sz, int off);
    ffra_pkg::req_t r;
    r.op = op;
    r.req_size = sz[ffra_pkg::FIELD_W-1:0];
    r.free_offset = off[ffra_pkg::FIELD_W-1:0];
    return r;
  endfunction

  function automatic void add_row(ffra_pkg::req_t r, logic chk, ffra_pkg::status_t st,
                                  int off);
    row_t w;
    w.req = r;
    w.chk = chk;
    w.res.status = st;
    w.res.alloc_offset = off[ffra_pkg::FIELD_W-1:0];
    rows.push_back(w);
  endfunction

  task automatic send_request(ffra_pkg::req_t r);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_range_op(r));
    if (r.op == ffra_pkg::OP_ALLOC) n_alloc++; else n_free++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %0d/%0d", out_res.status,
                                   out_res.alloc_offset);
      end else begin
        ffra_pkg::res_t e;
        e = pending_results.pop_front();
        if (out_res.status == ffra_pkg::STS_FULL) n_full++;
        if (out_res.status == ffra_pkg::STS_NOT_FOUND) n_nf++;
        if (out_res.status !== e.status || out_res.alloc_offset !== e.alloc_offset) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: status exp %0d got %0d, offset exp %0d got %0d",
                     e.status, out_res.status, e.alloc_offset, out_res.alloc_offset);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("first_fit_range_allocator_test: FAIL");
      $finish;
    end
  end

  initial begin
    ffra_pkg::req_t r;
    ffra_pkg::res_t e;
    tbl_count = 0;
    for (int k = 0; k < SLOTS; k++) begin
      tbl_start[k] = 0;
      tbl_end[k] = 0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(mk(ffra_pkg::OP_FREE, 0, 1), 1'b1, ffra_pkg::STS_NOT_FOUND, 0);
    add_row(mk(ffra_pkg::OP_ALLOC, 0, 0), 1'b1, ffra_pkg::STS_NO_SPACE, 0);
    add_row(mk(ffra_pkg::OP_ALLOC, 2047, 0), 1'b1, ffra_pkg::STS_OK, 1);
    add_row(mk(ffra_pkg::OP_ALLOC, 2047, 2047), 1'b1, ffra_pkg::STS_NO_SPACE, 0);
    add_row(mk(ffra_pkg::OP_FREE, 0, 1), 1'b1, ffra_pkg::STS_OK, 0);
    add_row(mk(ffra_pkg::OP_ALLOC, 10, 0), 1'b1, ffra_pkg::STS_OK, 1);
    add_row(mk(ffra_pkg::OP_ALLOC, 20, 0), 1'b1, ffra_pkg::STS_OK, 11);
    add_row(mk(ffra_pkg::OP_ALLOC, 2047, 0), 1'b0, ffra_pkg::STS_OK, 0);
    add_row(mk(ffra_pkg::OP_FREE, 0, 2047), 1'b1, ffra_pkg::STS_NOT_FOUND, 0);
    add_row(mk(ffra_pkg::OP_FREE, 0, 0), 1'b1, ffra_pkg::STS_NOT_FOUND, 0);
    add_row(mk(ffra_pkg::OP_FREE, 0, 1), 1'b1, ffra_pkg::STS_OK, 0);
    add_row(mk(ffra_pkg::OP_ALLOC, 5, 0), 1'b0, ffra_pkg::STS_OK, 0);
    add_row(mk(ffra_pkg::OP_FREE, 2047, 11), 1'b1, ffra_pkg::STS_OK, 0);
    add_row(mk(ffra_pkg::OP_ALLOC, 1, 0), 1'b0, ffra_pkg::STS_OK, 0);
    add_row(mk(ffra_pkg::OP_FREE, 0, 12), 1'b0, ffra_pkg::STS_OK, 0);
    for (int k = 0; k < 66; k++) begin
      add_row(mk(ffra_pkg::OP_ALLOC, 1, 0), 1'b0, ffra_pkg::STS_OK, 0);
    end
    add_row(mk(ffra_pkg::OP_ALLOC, 0, 0), 1'b1, ffra_pkg::STS_FULL, 0);
    add_row(mk(ffra_pkg::OP_FREE, 0, 30), 1'b0, ffra_pkg::STS_OK, 0);
    add_row(mk(ffra_pkg::OP_ALLOC, 1, 0), 1'b0, ffra_pkg::STS_OK, 0);
    add_row(mk(ffra_pkg::OP_ALLOC, 1, 0), 1'b1, ffra_pkg::STS_FULL, 0);

    foreach (rows[i]) begin
      send_request(rows[i].req);
      if (rows[i].chk) begin
        e = pending_results[$];
        if (e !== rows[i].res) begin
          errors++;
          if (errors <= 10) $display("table row %0d: typed %0d/%0d, predicted %0d/%0d",
                                     i, rows[i].res.status, rows[i].res.alloc_offset,
                                     e.status, e.alloc_offset);
        end
      end
    end

    for (int n = 0; n < NRAND; n++) begin
      int pick;
      if (n > NRAND - 150) gaps_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (n % 400 > 330 && tbl_count > 0) pick = 80;
      if (pick < 50) begin
        r = mk(ffra_pkg::OP_ALLOC, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                               : $urandom_range(1, 60), 0);
        r.free_offset = ffra_pkg::FIELD_W'($urandom);
      end else if (pick < 85 && tbl_count > 0) begin
        r = mk(ffra_pkg::OP_FREE, int'($urandom_range(0, 2047)),
               tbl_start[$urandom_range(0, tbl_count - 1)]);
      end else begin
        r.op = 1'($urandom);
        r.req_size = ffra_pkg::FIELD_W'($urandom);
        r.free_offset = ffra_pkg::FIELD_W'($urandom);
      end
      send_request(r);
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d allocate and %0d free requests; %0d table-full, %0d not-found.",
             n_alloc, n_free, n_full, n_nf);
    if (errors == 0) begin
      $display("first_fit_range_allocator_test: PASS");
    end else begin
      $display("Mismatches: %0d", errors);
      $display("first_fit_range_allocator_test: FAIL");
    end
    $finish;
  end

endmodule
